[design/mcwa_pkg.sv]
package mcwa_pkg;

	localparam int CHANNELS  = 8;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SHORT_LEN = 5;
	localparam int LONG_LEN  = 25;
	localparam int DIV_W     = 33;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// rounded-up reciprocals: 2^21/5 and 2^25/25, exact for numerators below 2^18 and 2^20
	localparam logic [20:0] RECIP_5  = 21'd419431;
	localparam logic [20:0] RECIP_25 = 21'd1342178;

	typedef enum logic {
		OP_LEVEL = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         chan;
		logic signed [15:0] level;
	} in_word_t;

	typedef struct packed {
		logic [5:0]         out_chan;
		logic signed [15:0] avg_long;
		logic signed [15:0] avg_short;
		logic signed [15:0] avg_base;
		logic               last;
	} out_word_t;

	typedef enum logic [1:0] {
		SEL_BASE,
		SEL_SHORT,
		SEL_LONG
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE_START,
		S_BASE_WAIT,
		S_SHORT_START,
		S_SHORT_WAIT,
		S_LONG_START,
		S_LONG_WAIT,
		S_EMIT,
		S_NEXT
	} state_t;

	typedef struct packed {
		logic            val_wr;
		logic            tick_start;
		logic            div_start;
		div_sel_t        div_sel;
		logic            base_wr;
		logic            short_wr;
		logic            long_wr;
		logic            out_load;
		logic [CH_W-1:0] idx;
		logic            last;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic wrap5;
		logic wrap25;
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

[design/mcwa_div.sv]
module mcwa_div
	import mcwa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [15:0]      den,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	logic [DIV_W-1:0]     sh_q;
	logic [15:0]          rem_q;
	logic [15:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [16:0]          trial;
	logic [16:0]          diff;
	logic                 ge;

	// one quotient bit per cycle, msb first
	assign trial = {rem_q, sh_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[15:0] : trial[15:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = sh_q;

endmodule

[design/mcwa_datapath.sv]
module mcwa_datapath
	import mcwa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data
);

	logic signed [31:0] win_sum_q   [CHANNELS];
	logic [15:0]        win_count_q [CHANNELS];
	logic signed [15:0] base_avg_q  [CHANNELS];
	logic signed [18:0] short_sum_q [CHANNELS];
	logic signed [20:0] long_sum_q  [CHANNELS];
	logic signed [15:0] short_avg_q [CHANNELS];
	logic signed [15:0] long_avg_q  [CHANNELS];
	logic [2:0]         mod5_q;
	logic [4:0]         mod25_q;
	logic               neg_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic [19:0]        recip_num_s1;
	logic               recip_long_s1;
	logic               recip_vld_s1;
	logic [16:0]        recip_quot_s2;
	logic               recip_done_s2;
	logic [20:0]        recip_m;
	logic [40:0]        recip_prod;
	logic [16:0]        recip_quot;

	logic [CH_W-1:0]    rd_idx;
	logic               chan_ok;
	logic [DIV_W-1:0]   div_x;
	logic [DIV_W-1:0]   div_mag;
	logic [DIV_W-1:0]   div_num;
	logic [15:0]        div_den;
	logic               ser_start;
	logic               ser_busy;
	logic               ser_done;
	logic [DIV_W-1:0]   ser_quot;
	logic               div_busy;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;
	logic [16:0]        q_clamp;
	logic [16:0]        q_neg;
	logic signed [15:0] div_res;
	logic signed [15:0] base_val;

	// level words use the input channel, tick walks use the controller index
	assign rd_idx  = cmd.val_wr ? in_data.chan[CH_W-1:0] : cmd.idx;
	assign chan_ok = {1'b0, in_data.chan} < 7'(CHANNELS);

	always_comb begin
		unique case (cmd.div_sel)
			SEL_BASE: begin
				div_x   = {win_sum_q[rd_idx][31], win_sum_q[rd_idx]};
				div_den = win_count_q[rd_idx];
			end
			SEL_SHORT: begin
				div_x   = {{(DIV_W-19){short_sum_q[rd_idx][18]}}, short_sum_q[rd_idx]};
				div_den = 16'(SHORT_LEN);
			end
			SEL_LONG: begin
				div_x   = {{(DIV_W-21){long_sum_q[rd_idx][20]}}, long_sum_q[rd_idx]};
				div_den = 16'(LONG_LEN);
			end
			default: begin
				div_x   = '0;
				div_den = 16'd1;
			end
		endcase
	end

	// round half away from zero: divide |x| + den/2
	assign div_mag = div_x[DIV_W-1] ? (~div_x + 1'b1) : div_x;
	assign div_num = div_mag + {{(DIV_W-15){1'b0}}, div_den[15:1]};

	// serial divider only for sum/count
	assign ser_start = cmd.div_start && (cmd.div_sel == SEL_BASE);

	mcwa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ser_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (ser_busy),
		.done   (ser_done),
		.quot   (ser_quot)
	);

	// divide by 5 or 25: multiply by the reciprocal, keep the bits above the shift
	assign recip_m    = recip_long_s1 ? RECIP_25 : RECIP_5;
	assign recip_prod = {21'd0, recip_num_s1} * {20'd0, recip_m};
	assign recip_quot = recip_long_s1 ? {1'b0, recip_prod[40:25]} : recip_prod[37:21];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_vld_s1  <= 1'b0;
			recip_done_s2 <= 1'b0;
		end else begin
			recip_vld_s1  <= cmd.div_start && (cmd.div_sel != SEL_BASE);
			recip_done_s2 <= recip_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q         <= div_x[DIV_W-1];
			recip_num_s1  <= div_num[19:0];
			recip_long_s1 <= cmd.div_sel == SEL_LONG;
		end
		if (recip_vld_s1) begin
			recip_quot_s2 <= recip_quot;
		end
	end

	assign div_busy = ser_busy || recip_vld_s1;
	assign div_done = ser_done || recip_done_s2;
	assign div_quot = (cmd.div_sel == SEL_BASE) ? ser_quot
		: {{(DIV_W-17){1'b0}}, recip_quot_s2};

	always_comb begin
		q_clamp = (div_quot > DIV_W'(32768)) ? 17'd32768 : div_quot[16:0];
		q_neg   = ~q_clamp + 1'b1;
		if (neg_q) begin
			div_res = q_neg[15:0];
		end else begin
			div_res = (q_clamp > 17'd32767) ? 16'sh7FFF : q_clamp[15:0];
		end
	end

	assign base_val = (win_count_q[rd_idx] == 16'd0) ? 16'sd0 : div_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				win_sum_q[i]   <= '0;
				win_count_q[i] <= '0;
				base_avg_q[i]  <= '0;
				short_sum_q[i] <= '0;
				long_sum_q[i]  <= '0;
				short_avg_q[i] <= '0;
				long_avg_q[i]  <= '0;
			end
			mod5_q  <= '0;
			mod25_q <= '0;
		end else begin
			if (cmd.val_wr && chan_ok && (win_count_q[rd_idx] != COUNT_MAX)) begin
				win_count_q[rd_idx] <= win_count_q[rd_idx] + 16'd1;
				win_sum_q[rd_idx]   <= win_sum_q[rd_idx] + 32'(in_data.level);
			end
			if (cmd.tick_start) begin
				mod5_q  <= st.wrap5 ? 3'd0 : mod5_q + 3'd1;
				mod25_q <= st.wrap25 ? 5'd0 : mod25_q + 5'd1;
			end
			if (cmd.base_wr) begin
				base_avg_q[rd_idx]  <= base_val;
				win_sum_q[rd_idx]   <= '0;
				win_count_q[rd_idx] <= '0;
				short_sum_q[rd_idx] <= short_sum_q[rd_idx] + 19'(base_val);
				long_sum_q[rd_idx]  <= long_sum_q[rd_idx] + 21'(base_val);
			end
			if (cmd.short_wr) begin
				short_avg_q[rd_idx] <= div_res;
				short_sum_q[rd_idx] <= '0;
			end
			if (cmd.long_wr) begin
				long_avg_q[rd_idx] <= div_res;
				long_sum_q[rd_idx] <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.out_chan  <= 6'(cmd.idx);
			out_q.avg_long  <= long_avg_q[rd_idx];
			out_q.avg_short <= short_avg_q[rd_idx];
			out_q.avg_base  <= base_avg_q[rd_idx];
			out_q.last      <= cmd.last;
		end
	end

	assign st.count_zero = win_count_q[rd_idx] == 16'd0;
	assign st.wrap5      = mod5_q == 3'(SHORT_LEN - 1);
	assign st.wrap25     = mod25_q == 5'(LONG_LEN - 1);
	assign st.div_busy   = div_busy;
	assign st.div_done   = div_done;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/mcwa_ctrl.sv]
module mcwa_ctrl
	import mcwa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	state_t          state_q;
	state_t          state_d;
	logic [CH_W-1:0] idx_q;
	logic            wrap5_q;
	logic            wrap25_q;
	logic            is_last;
	logic            idx_inc;
	state_t          after_base;
	state_t          after_short;

	assign is_last     = idx_q == CH_W'(CHANNELS - 1);
	assign after_base  = wrap5_q ? S_SHORT_START : (wrap25_q ? S_LONG_START : S_NEXT);
	assign after_short = wrap25_q ? S_LONG_START : S_NEXT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			wrap5_q  <= 1'b0;
			wrap25_q <= 1'b0;
		end else if (cmd.tick_start) begin
			idx_q    <= '0;
			wrap5_q  <= st.wrap5;
			wrap25_q <= st.wrap25;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		idx_inc        = 1'b0;
		cmd            = '0;
		cmd.div_sel    = SEL_BASE;
		cmd.idx        = idx_q;
		cmd.last       = is_last;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LEVEL) begin
						cmd.val_wr = 1'b1;
					end else begin
						cmd.tick_start = 1'b1;
						state_d        = S_BASE_START;
					end
				end
			end
			S_BASE_START: begin
				if (st.count_zero) begin
					cmd.base_wr = 1'b1;
					state_d     = after_base;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_BASE_WAIT;
				end
			end
			S_BASE_WAIT: begin
				if (st.div_done) begin
					cmd.base_wr = 1'b1;
					state_d     = after_base;
				end
			end
			S_SHORT_START: begin
				cmd.div_sel   = SEL_SHORT;
				cmd.div_start = 1'b1;
				state_d       = S_SHORT_WAIT;
			end
			S_SHORT_WAIT: begin
				cmd.div_sel = SEL_SHORT;
				if (st.div_done) begin
					cmd.short_wr = 1'b1;
					state_d      = after_short;
				end
			end
			S_LONG_START: begin
				cmd.div_sel   = SEL_LONG;
				cmd.div_start = 1'b1;
				state_d       = S_LONG_WAIT;
			end
			S_LONG_WAIT: begin
				cmd.div_sel = SEL_LONG;
				if (st.div_done) begin
					cmd.long_wr = 1'b1;
					state_d     = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					idx_inc      = !is_last;
					state_d      = is_last ? S_IDLE : S_BASE_START;
				end
			end
			S_NEXT: begin
				idx_inc = !is_last;
				state_d = is_last ? S_IDLE : S_BASE_START;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register must never be overwritten while holding a word
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> st.out_free)
		else $error("result loaded into an occupied output register");

	// a division is started only when neither divider is busy
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_start |-> !st.div_busy)
		else $error("divider restarted while busy");

	// no division may still run once the walk has ended
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !st.div_busy)
		else $error("divider busy while idle");

	// a short or long average is only written back on divider completion
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.short_wr || cmd.long_wr) |-> st.div_done)
		else $error("average written without a finished division");

endmodule

[design/multichannel_cascaded_window_average.sv]
// per-channel boxcar level averaging with decimation by 5 and by 25
//
// input channel (in_valid/in_ready/in_data): one word is either a level
// value (opcode 0: signed q8.8 dbfs level for channel chan) or a window
// tick (opcode 1). a level word leaves the block idle, so level words can stream
// back to back; a word for a channel outside the configured count, or for a
// channel whose count has saturated, is dropped.
// a tick is accepted, then the block walks all channels in order. per
// channel: base average = sum/count through a 33-step restoring divider
// (skipped when the window is empty), on every 5th tick the short average
// and on every 25th tick the long average (each by reciprocal multiply),
// then one step state or the load of one output word. in_ready is low
// throughout the walk.
// output channel (out_valid/out_ready/out_data): on every 25th tick one word
// per channel, channel 0 first, last set on the final channel. a single
// output register holds each word; while the receiver stalls the walk waits
// in front of that register, and the block goes back to accepting input as
// soon as the final word is loaded, even if it has not been taken.
// reset (arst_n low) clears all sums, counts, averages and tick counters.
module multichannel_cascaded_window_average
	import mcwa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// command and status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t st;

	// sequencer: accepts words, walks channels on a tick, paces the divider
	mcwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.opcode),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: per-channel state, divider, output register
	mcwa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[tb/tb.sv]
module tb;
	import mcwa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no word moving on either side before the run is called hung
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_WORDS   = 270;
	// keep going until this many long-window results have been predicted
	localparam int RESULTS_WANTED = 32;
	// settle time after the last expected result
	localparam int TAIL_CYCLES    = 200;

	// predicts the per-channel averages and holds the results still to come
	class window_average_board;
		int        win_sum   [CHANNELS];
		int        win_count [CHANNELS];
		int        base_avg  [CHANNELS];
		int        short_sum [CHANNELS];
		int        long_sum  [CHANNELS];
		int        short_avg [CHANNELS];
		int        long_avg  [CHANNELS];
		int        tick5;
		int        tick25;
		out_word_t pending_avgs[$];
		int        results_due;
		int        mismatches;

		function new();
			for (int i = 0; i < CHANNELS; i++) begin
				win_sum[i]   = 0;
				win_count[i] = 0;
				base_avg[i]  = 0;
				short_sum[i] = 0;
				long_sum[i]  = 0;
				short_avg[i] = 0;
				long_avg[i]  = 0;
			end
			tick5       = 0;
			tick25      = 0;
			results_due = 0;
			mismatches  = 0;
		endfunction

		// round to nearest, ties away from zero, clamped to 16 bits signed
		function int round_div(longint num, int den);
			longint mag;
			longint q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			if (q > 32768)
				q = 32768;
			if (num < 0)
				return -int'(q);
			if (q > 32767)
				q = 32767;
			return int'(q);
		endfunction

		function void note_word(in_word_t w);
			int        ch;
			int        lv;
			out_word_t r;
			if (w.opcode == OP_LEVEL) begin
				ch = w.chan;
				lv = w.level;
				if (ch >= CHANNELS)
					return;
				if (win_count[ch] >= int'(COUNT_MAX))
					return;
				win_count[ch]++;
				win_sum[ch] += lv;
				return;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				base_avg[i] = (win_count[i] != 0) ? round_div(win_sum[i], win_count[i]) : 0;
				win_sum[i]   = 0;
				win_count[i] = 0;
				short_sum[i] += base_avg[i];
				long_sum[i]  += base_avg[i];
			end
			tick5++;
			if (tick5 >= SHORT_LEN) begin
				tick5 = 0;
				for (int i = 0; i < CHANNELS; i++) begin
					short_avg[i] = round_div(short_sum[i], SHORT_LEN);
					short_sum[i] = 0;
				end
			end
			tick25++;
			if (tick25 >= LONG_LEN) begin
				tick25 = 0;
				for (int i = 0; i < CHANNELS; i++) begin
					long_avg[i]  = round_div(long_sum[i], LONG_LEN);
					long_sum[i]  = 0;
					r.out_chan   = 6'(i);
					r.avg_long   = 16'(long_avg[i]);
					r.avg_short  = 16'(short_avg[i]);
					r.avg_base   = 16'(base_avg[i]);
					r.last       = (i == CHANNELS - 1);
					pending_avgs = {pending_avgs, r};
					results_due++;
				end
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (pending_avgs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: chan %0d long %0d short %0d base %0d last %0d",
						got.out_chan, got.avg_long, got.avg_short, got.avg_base, got.last);
				return;
			end
			want = pending_avgs.pop_front();
			if (got.out_chan !== want.out_chan || got.avg_long !== want.avg_long ||
					got.avg_short !== want.avg_short || got.avg_base !== want.avg_base ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch, expected: chan %0d long %0d short %0d base %0d last %0d",
						want.out_chan, want.avg_long, want.avg_short, want.avg_base, want.last);
					$display("                 actual:   chan %0d long %0d short %0d base %0d last %0d",
						got.out_chan, got.avg_long, got.avg_short, got.avg_base, got.last);
				end
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// when set, neither side starts a new gap
	logic calm = 1'b0;
	int   stall_left = 0;
	int   idle_cycles = 0;

	window_average_board board = new();

	multichannel_cascaded_window_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5ns clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_word_t level_word(int ch, int lv);
		in_word_t w;
		w.opcode = OP_LEVEL;
		w.chan   = ch[5:0];
		w.level  = lv[15:0];
		return w;
	endfunction

	// chan and level carry noise on a tick, the block must ignore them
	function automatic in_word_t tick_word();
		in_word_t w;
		w.opcode = OP_TICK;
		w.chan   = 6'($urandom);
		w.level  = 16'($urandom);
		return w;
	endfunction

	// hold valid from the falling edge until a rising edge sees ready
	task automatic send_word(in_word_t w);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// receiver side: random stalls on out_ready, none started while calm
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// both handshakes are seen at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_word(in_data);
		if (arst_n && out_valid && out_ready)
			board.check_word(out_data);
	end

	// hang detector: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int sent;
		int r;
		int ch;
		int lv;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, rounding ties both ways, ignored channels
		send_word(level_word(0, 32767));
		send_word(level_word(0, 32767));
		send_word(level_word(1, -32768));
		send_word(level_word(7, -32768));
		send_word(level_word(7, 32767));        // -0.5 rounds to -1
		send_word(level_word(2, 1));
		send_word(level_word(2, 2));            // 1.5 rounds to 2
		send_word(level_word(8, 1000));         // first channel out of range
		send_word(level_word(63, -1));          // top channel code, ignored
		// channels 3..6 stay empty on this tick, base average 0
		send_word(tick_word());

		// walk up to one tick before the long period wraps
		for (int t = 1; t < LONG_LEN - 1; t++) begin
			if (t % 4 == 0)
				send_word(level_word(6, t * 1300 - 16000));
			send_word(tick_word());
		end

		// a few words on channel 5, the wrapping tick shows them in avg_base
		send_word(level_word(5, -32768));
		send_word(level_word(5, 32767));
		send_word(level_word(5, -3));
		send_word(tick_word());

		// random part: mostly sensible traffic, some stray channels
		sent = 0;
		while (sent < RANDOM_WORDS || board.results_due < RESULTS_WANTED) begin
			if (sent % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_word(tick_word());
			end else begin
				if ($urandom_range(0, 99) < 85)
					ch = $urandom_range(0, CHANNELS - 1);
				else
					ch = $urandom_range(0, 63);
				case ($urandom_range(0, 3))
					0: lv = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
					1: lv = $urandom_range(0, 8) - 4;
					default: lv = int'($signed(16'($urandom)));
				endcase
				send_word(level_word(ch, lv));
			end
			sent++;
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;

		// drain: the watchdog covers a result that never shows up
		while (board.pending_avgs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending_avgs.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

[files.f]
design/mcwa_pkg.sv
design/mcwa_div.sv
design/mcwa_datapath.sv
design/mcwa_ctrl.sv
design/multichannel_cascaded_window_average.sv
tb/tb.sv
